/* hw/rtl/kfr_pkg.sv */
package kfr_pkg;

  localparam int unsigned ROM_BYTES_DEF = 262144;
  localparam int unsigned PTR_W = 17;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PORT_W = 16;

  typedef enum logic [1:0] {
    REQ_PORT_WR = 2'd0,
    REQ_PORT_RD = 2'd1,
    REQ_MM_RD   = 2'd2,
    REQ_LOAD    = 2'd3
  } req_t;

  localparam logic [PORT_W-1:0] PORT_CODE_HI = 16'hff94;
  localparam logic [PORT_W-1:0] PORT_CODE_LO = 16'hff95;
  localparam logic [PORT_W-1:0] PORT_DATA_LO = 16'hff96;
  localparam logic [PORT_W-1:0] PORT_DATA_HI = 16'hff97;
  localparam logic [PORT_W-1:0] PORT_DATA_HI_ALT = 16'hff9c;
  localparam logic [PORT_W-1:0] PORT_DATA_LO_ALT = 16'hff9d;
  localparam logic [PORT_W-1:0] PORT_ROW = 16'hff9e;

  localparam logic [ADDR_W-1:0] WIN_FULL_BASE = 32'hc2100000;
  localparam logic [ADDR_W-1:0] WIN_FULL_MASK = 32'hfffc0000;
  localparam logic [ADDR_W-1:0] WIN_A_BASE = 32'h000ca000;
  localparam logic [ADDR_W-1:0] WIN_A_MASK = 32'hfffff800;
  localparam logic [ADDR_W-1:0] WIN_B_BASE = 32'h000cb000;
  localparam logic [ADDR_W-1:0] WIN_B_MASK = 32'hfffff000;
  localparam logic [17:0] WIN_A_OFFSET = 18'h3d000;
  localparam logic [17:0] WIN_B_OFFSET = 18'h3d800;

  // Word pointer of the first glyph row for a character code.
  function automatic logic [PTR_W-1:0] glyph_pointer(input logic [7:0] hi,
                                                     input logic [7:0] lo);
    logic [3:0]  bank;
    logic [7:0]  mid;
    logic [7:0]  hsub;
    logic [19:0] sum;
    logic [PTR_W-1:0] p;
    bank = hi[7:4];
    mid  = lo - 8'h20;
    hsub = (hi - 8'h30) & 8'h70;
    sum  = 20'd0;
    p    = '0;
    if (bank >= 4'd3 && bank <= 4'd6) begin
      sum = {10'd0, lo[4:0], 5'd0}
          + {4'd0, mid[6:5], 14'd0}
          + {6'd0, hi[3:0], 10'd0}
          + 20'({12'd0, hsub} * 20'h00c00)
          + 20'h08000;
      p = sum[PTR_W:1];
    end else begin
      p = {8'd0, lo[4:0], 4'd0} | {3'd0, mid[5], 13'd0} | {4'd0, mid[6], 12'd0}
        | {5'd0, hi[2:0], 9'd0};
      if (bank > 4'd6) begin
        p = p | 17'h1c000;
      end
    end
    return p;
  endfunction

endpackage

/* hw/rtl/kfr_store.sv */
module kfr_store
  import kfr_pkg::*;
#(
  parameter int unsigned DEPTH = ROM_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [BYTE_W-1:0]        wr_data,
  output logic [BYTE_W-1:0]        rd_data_r
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule

/* hw/rtl/kanji_font_rom_port.sv */
// Font ROM port with a character-code pointer.
// The input channel carries one bus access per transaction: in_tuser is the
// request kind (port write, port read, memory-mapped read, ROM byte load),
// in_tdata holds the address and the write byte. Port reads and memory-mapped
// reads each return one byte on the output channel; writes and loads return
// nothing. The glyph store is a single-port synchronous RAM of ROM_BYTES
// bytes, read or written at most once per accepted transaction.
// A read result passes through the RAM read register and then the output
// register before it appears on out_tdata. One transaction can be accepted
// every cycle unless out_tready is held low; one RAM port sets that figure.
// Reset clears the character code and the word pointer; the store keeps its
// contents and must be loaded before it is read. When the receiver holds
// out_tready low, the output register and the read stage fill and in_tready
// drops until the result is taken; nothing is lost.
module kanji_font_rom_port
  import kfr_pkg::*;
#(
  parameter int unsigned ROM_BYTES = ROM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] address, [39:32] write_data
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] read_data
);

  localparam int unsigned AW = $clog2(ROM_BYTES);

  req_t              req;
  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] wdata;
  logic [PORT_W-1:0] port;
  logic              acc;

  logic [7:0]        code_hi_r, code_hi_nxt;
  logic [7:0]        code_lo_r, code_lo_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;

  // Read stage: the RAM data or an immediate byte is pending.
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_use_mem_r, s1_use_mem_nxt;
  logic [BYTE_W-1:0] s1_imm_r, s1_imm_nxt;
  logic              s1_go;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;

  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_rdata;

  logic [17:0]       win_a_idx;
  logic [17:0]       win_b_idx;
  logic              has_result;

  assign req   = req_t'(in_tuser);
  assign addr  = in_tdata[31:0];
  assign wdata = in_tdata[39:32];
  assign port  = addr[PORT_W-1:0];

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign acc       = in_tvalid && in_tready;

  assign win_a_idx = WIN_A_OFFSET + {7'd0, addr[10:0]};
  assign win_b_idx = WIN_B_OFFSET + {6'd0, addr[11:0]};

  always_comb begin
    code_hi_nxt    = code_hi_r;
    code_lo_nxt    = code_lo_r;
    ptr_nxt        = ptr_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = addr[AW-1:0];
    has_result     = 1'b0;
    s1_use_mem_nxt = s1_use_mem_r;
    s1_imm_nxt     = s1_imm_r;
    if (acc) begin
      case (req)
        REQ_PORT_WR: begin
          case (port)
            PORT_CODE_HI: begin
              code_hi_nxt = wdata;
              ptr_nxt     = glyph_pointer(wdata, code_lo_r);
            end
            PORT_CODE_LO: begin
              code_lo_nxt = wdata;
              ptr_nxt     = glyph_pointer(code_hi_r, wdata);
            end
            PORT_ROW: begin
              ptr_nxt = {ptr_r[PTR_W-1:4], wdata[3:0]};
            end
            default: begin
            end
          endcase
        end
        REQ_PORT_RD: begin
          has_result     = 1'b1;
          s1_use_mem_nxt = 1'b0;
          s1_imm_nxt     = 8'h00;
          case (port)
            PORT_CODE_HI: s1_imm_nxt = 8'h80;
            PORT_CODE_LO: s1_imm_nxt = 8'hff;
            PORT_DATA_LO, PORT_DATA_LO_ALT: begin
              s1_use_mem_nxt = 1'b1;
              mem_re         = 1'b1;
              mem_addr       = AW'({ptr_r, 1'b0});
            end
            PORT_DATA_HI, PORT_DATA_HI_ALT: begin
              s1_use_mem_nxt = 1'b1;
              mem_re         = 1'b1;
              mem_addr       = AW'({ptr_r, 1'b1});
              ptr_nxt        = ptr_r + 1'b1;
            end
            PORT_ROW: s1_imm_nxt = {4'd0, ptr_r[3:0]};
            default: begin
            end
          endcase
        end
        REQ_MM_RD: begin
          has_result     = 1'b1;
          s1_use_mem_nxt = 1'b1;
          s1_imm_nxt     = 8'hff;
          mem_re         = 1'b1;
          if ((addr & WIN_FULL_MASK) == WIN_FULL_BASE) begin
            mem_addr = addr[AW-1:0];
          end else if ((addr & WIN_A_MASK) == WIN_A_BASE) begin
            mem_addr = win_a_idx[AW-1:0];
          end else if ((addr & WIN_B_MASK) == WIN_B_BASE) begin
            mem_addr = win_b_idx[AW-1:0];
          end else begin
            s1_use_mem_nxt = 1'b0;
            mem_re         = 1'b0;
          end
        end
        REQ_LOAD: begin
          mem_we = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    if (acc && has_result) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = s1_use_mem_r ? mem_rdata : s1_imm_r;
    end
  end

  kfr_store #(
    .DEPTH(ROM_BYTES)
  ) u_store (
    .clk      (clk),
    .wr_en    (mem_we),
    .rd_en    (mem_re),
    .addr     (mem_addr),
    .wr_data  (wdata),
    .rd_data_r(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_hi_r   <= '0;
      code_lo_r   <= '0;
      ptr_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      code_hi_r   <= code_hi_nxt;
      code_lo_r   <= code_lo_nxt;
      ptr_r       <= ptr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_use_mem_r <= s1_use_mem_nxt;
    s1_imm_r     <= s1_imm_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
